/* rtl/sobel_pkg.sv */
`timescale 1ns / 1ps

package sobel_pkg;

  // Frame geometry and pixel depth
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int PIXEL_BITS   = 8;

  // Port field widths
  localparam int PIX_PORT_W  = 8;
  localparam int EDGE_PORT_W = 11;
  localparam int ROW_PORT_W  = 8;
  localparam int COL_PORT_W  = 9;

  // Internal widths
  localparam int COL_CW = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
  localparam int ROW_CW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  typedef logic [PIXEL_BITS-1:0]        pixel_t;
  typedef logic [COL_CW-1:0]            col_t;
  typedef logic [ROW_CW-1:0]            row_t;
  typedef logic [PIXEL_BITS+1:0]        sum_t;   // top + 2*mid + bottom
  typedef logic signed [PIXEL_BITS:0]   diff_t;  // bottom - top
  typedef logic signed [PIXEL_BITS+2:0] grad_t;
  typedef logic [PIXEL_BITS+2:0]        mag_t;

  typedef logic [PIX_PORT_W-1:0]  pix_port_t;
  typedef logic [EDGE_PORT_W-1:0] edge_port_t;
  typedef logic [ROW_PORT_W-1:0]  row_port_t;
  typedef logic [COL_PORT_W-1:0]  col_port_t;

  // One window column, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Per-column partial terms of the two kernels
  typedef struct packed {
    sum_t  vsum;
    diff_t vdiff;
  } col_terms_t;

  function automatic col_terms_t col_terms(input column_t c);
    col_terms_t r;
    r.vsum  = sum_t'(c.top) + (sum_t'(c.mid) << 1) + sum_t'(c.bot);
    r.vdiff = diff_t'({1'b0, c.bot}) - diff_t'({1'b0, c.top});
    return r;
  endfunction

  function automatic grad_t abs_grad(input grad_t g);
    return (g < 0) ? -g : g;
  endfunction

endpackage

/* rtl/sobel_ram.sv */
`timescale 1ns / 1ps

module sobel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sobel_cell.sv */
`timescale 1ns / 1ps

// One window column: hold it, pass it on to the next cell on shift.
module sobel_cell (
  input  logic                  clk,
  input  logic                  shift,
  input  sobel_pkg::column_t    col_in,
  output sobel_pkg::column_t    col_out
);

  sobel_pkg::column_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

/* rtl/sobel_edge_magnitude_stream_unit.sv */
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// --------+--------------------+--------------------------------------------------
// in      | in_valid/in_ready  | pixel_value, frame_start
// out     | out_valid/out_ready| edge_magnitude, center_row, center_col, frame_last
//
// One pixel is taken per clock while the output is not stalled; the three-stage pipeline
// (line-store read, gradient, magnitude) advances only where the stage below has room.
// An accepted pixel's result passes the stage 1, stage 2 and output registers in turn.
// Synchronous reset clears pipeline valids and the position counters; the line
// store is not cleared.
// A stalled output holds the pipeline back stage by stage; in_ready falls only in reset
// or once every stage is full with a pixel that yields a result.

module sobel_edge_magnitude_stream_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sobel_pkg::pix_port_t       pixel_value,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sobel_pkg::edge_port_t      edge_magnitude,
  output sobel_pkg::row_port_t       center_row,
  output sobel_pkg::col_port_t       center_col,
  output logic                       frame_last
);

  // ---------------------------------------------------------------------------
  // Handshake and stage advance
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid;
  logic s1_emit;
  logic s1_go, s2_go, s2_free, out_free, in_take;

  assign out_free = !out_valid || out_ready;
  assign s2_go    = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_go;
  // A pixel that yields no result retires from stage 1 without a slot below
  assign s1_go    = s1_valid && (!s1_emit || s2_free);
  // Take nothing while reset is held
  assign in_ready = !rst && (!s1_valid || s1_go);
  assign in_take  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Position of the incoming pixel
  // ---------------------------------------------------------------------------
  sobel_pkg::col_t col_cnt, col_cur, col_cnt_next;
  sobel_pkg::row_t row_cnt, row_cur, row_cnt_next;
  logic            col_end, row_end;

  always_comb begin
    col_cur = frame_start ? '0 : col_cnt;
    row_cur = frame_start ? '0 : row_cnt;
    col_end = (col_cur == sobel_pkg::col_t'(sobel_pkg::FRAME_WIDTH - 1));
    row_end = (row_cur == sobel_pkg::row_t'(sobel_pkg::FRAME_HEIGHT - 1));
    // Wrap at the end of a row and at the end of the frame
    col_cnt_next = col_end ? '0 : col_cur + 1'b1;
    if (col_end) begin
      row_cnt_next = row_end ? '0 : row_cur + 1'b1;
    end else begin
      row_cnt_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_take) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel waits for its line-store read
  // ---------------------------------------------------------------------------
  sobel_pkg::pixel_t s1_pix;
  sobel_pkg::col_t   s1_col;
  sobel_pkg::row_t   s1_crow;
  sobel_pkg::col_t   s1_ccol;
  logic              s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix  <= pixel_value[sobel_pkg::PIXEL_BITS-1:0];
      s1_col  <= col_cur;
      // Results exist only for pixels at row 2 and column 2 or beyond
      s1_emit <= (row_cur >= sobel_pkg::row_t'(2)) && (col_cur >= sobel_pkg::col_t'(2));
      s1_crow <= row_cur - 1'b1;
      s1_ccol <= col_cur - 1'b1;
      s1_last <= row_end && col_end;
    end
  end

  // Line store: one word per column, {row two above, row one above}
  logic [2*sobel_pkg::PIXEL_BITS-1:0] ls_rd, ls_wr;
  sobel_pkg::pixel_t                  ls_top, ls_mid;

  assign ls_top = ls_rd[2*sobel_pkg::PIXEL_BITS-1:sobel_pkg::PIXEL_BITS];
  assign ls_mid = ls_rd[sobel_pkg::PIXEL_BITS-1:0];
  // Age the column: the row one above moves to two above, the new pixel to one above
  assign ls_wr  = {ls_mid, s1_pix};

  sobel_ram #(
    .WIDTH (2 * sobel_pkg::PIXEL_BITS),
    .DEPTH (sobel_pkg::FRAME_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (ls_wr),
    .rd_en   (in_take),
    .rd_addr (col_cur),
    .rd_data (ls_rd)
  );

  // ---------------------------------------------------------------------------
  // Window: current column is live, two stored columns shift through cells
  // ---------------------------------------------------------------------------
  sobel_pkg::column_t    cur_col, c0_col, c1_col;
  sobel_pkg::col_terms_t cur_terms, c0_terms, c1_terms;

  assign cur_col.top = ls_top;
  assign cur_col.mid = ls_mid;
  assign cur_col.bot = s1_pix;
  assign cur_terms   = sobel_pkg::col_terms(cur_col);
  assign c0_terms    = sobel_pkg::col_terms(c0_col);
  assign c1_terms    = sobel_pkg::col_terms(c1_col);

  // Column one to the left
  sobel_cell u_cell0 (
    .clk     (clk),
    .shift   (s1_go),
    .col_in  (cur_col),
    .col_out (c0_col)
  );

  // Column two to the left
  sobel_cell u_cell1 (
    .clk     (clk),
    .shift   (s1_go),
    .col_in  (c0_col),
    .col_out (c1_col)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: signed gradients
  // ---------------------------------------------------------------------------
  sobel_pkg::grad_t gx_next, gy_next, s2_gx, s2_gy;
  sobel_pkg::row_t  s2_crow;
  sobel_pkg::col_t  s2_ccol;
  logic             s2_last;

  assign gx_next = sobel_pkg::grad_t'(cur_terms.vsum) - sobel_pkg::grad_t'(c1_terms.vsum);
  assign gy_next = sobel_pkg::grad_t'(c1_terms.vdiff)
                 + (sobel_pkg::grad_t'(c0_terms.vdiff) <<< 1)
                 + sobel_pkg::grad_t'(cur_terms.vdiff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_go && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_go && s1_emit) begin
      s2_gx   <= gx_next;
      s2_gy   <= gy_next;
      s2_crow <= s1_crow;
      s2_ccol <= s1_ccol;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: magnitude |Gx| + |Gy|
  // ---------------------------------------------------------------------------
  sobel_pkg::mag_t mag_next, out_mag;
  sobel_pkg::row_t out_crow;
  sobel_pkg::col_t out_ccol;
  logic            out_last;

  assign mag_next = sobel_pkg::mag_t'(sobel_pkg::abs_grad(s2_gx))
                  + sobel_pkg::mag_t'(sobel_pkg::abs_grad(s2_gy));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_mag  <= mag_next;
      out_crow <= s2_crow;
      out_ccol <= s2_ccol;
      out_last <= s2_last;
    end
  end

  assign edge_magnitude = sobel_pkg::edge_port_t'(out_mag);
  assign center_row     = sobel_pkg::row_port_t'(out_crow);
  assign center_col     = sobel_pkg::col_port_t'(out_ccol);
  assign frame_last     = out_last;

endmodule

/* rtl/sobel_checker.sv */
`timescale 1ns / 1ps

module sobel_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input sobel_pkg::edge_port_t edge_magnitude,
  input sobel_pkg::row_port_t  center_row,
  input sobel_pkg::col_port_t  center_col,
  input logic                  frame_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_magnitude)
      && $stable(center_row) && $stable(center_col) && $stable(frame_last))
    else $error("stalled result changed");

  // Drop any result after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> center_row >= 1 && center_row <= sobel_pkg::FRAME_HEIGHT - 2
      && center_col >= 1 && center_col <= sobel_pkg::FRAME_WIDTH - 2)
    else $error("result outside the frame interior");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> center_row == sobel_pkg::FRAME_HEIGHT - 2
      && center_col == sobel_pkg::FRAME_WIDTH - 2)
    else $error("frame_last away from the final interior pixel");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> edge_magnitude <= 8 * ((1 << sobel_pkg::PIXEL_BITS) - 1))
    else $error("magnitude out of range");

endmodule

bind sobel_edge_magnitude_stream_unit sobel_checker u_sobel_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .edge_magnitude (edge_magnitude),
  .center_row     (center_row),
  .center_col     (center_col),
  .frame_last     (frame_last)
);

/* verif/sobel_edge_magnitude_stream_unit_test.sv */
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_unit_test;
  import sobel_pkg::*;

  // Generous ceiling: the slowest legal run (every pixel and every result
  // waiting out the longest gap) stays well below this.
  localparam int CYCLE_LIMIT = 300_000;
  localparam int RANDOM_PIXELS = 70;
  localparam int MAX_IDLE = 17;
  localparam int REPORT_LIMIT = 10;

  // Image content used to build pixel streams
  typedef enum int {
    PAT_FLAT_LOW,
    PAT_FLAT_HIGH,
    PAT_VERT_EDGE,
    PAT_HORIZ_EDGE,
    PAT_DIAG_STEP,
    PAT_CHECKER,
    PAT_RAMP,
    PAT_EXTREME,
    PAT_NOISE
  } pattern_e;

  typedef struct {
    edge_port_t magnitude;
    row_port_t  row;
    col_port_t  col;
    logic       last;
  } edge_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pix_port_t  pixel_value = '0;
  logic       frame_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  edge_port_t edge_magnitude;
  row_port_t  center_row;
  col_port_t  center_col;
  logic       frame_last;

  // Shadow copy of the block's position and neighbourhood
  pixel_t line_two_up[FRAME_WIDTH];
  pixel_t line_one_up[FRAME_WIDTH];
  pixel_t window_px[6];
  int     next_col;
  int     next_row;

  edge_result_t pending_edges[$];
  int  mismatch_count = 0;
  int  results_seen = 0;
  int  results_paced = 0;
  int  cycle_count = 0;
  int  ready_hold = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  sobel_edge_magnitude_stream_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_value    (pixel_value),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edge_magnitude (edge_magnitude),
    .center_row     (center_row),
    .center_col     (center_col),
    .frame_last     (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow state by one accepted pixel and queue the edge result
  // it produces, if the pixel completes an interior 3x3 neighbourhood.
  function automatic void predict_edge(input pix_port_t pix_in, input logic fs);
    int pix;
    int top_px;
    int mid_px;
    int gx;
    int gy;
    int col;
    int row;
    edge_result_t res;
    pix = int'(pix_in) & ((1 << PIXEL_BITS) - 1);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    if (next_col >= FRAME_WIDTH) next_col = 0;
    if (next_row >= FRAME_HEIGHT) next_row = 0;
    col = next_col;
    row = next_row;
    top_px = int'(line_two_up[col]);
    mid_px = int'(line_one_up[col]);

    if (row >= 2 && col >= 2) begin
      // Window entries 0..2 hold column col-2, 3..5 column col-1, top down
      gx = (top_px + 2 * mid_px + pix)
         - (int'(window_px[0]) + 2 * int'(window_px[1]) + int'(window_px[2]));
      gy = (int'(window_px[2]) + 2 * int'(window_px[5]) + pix)
         - (int'(window_px[0]) + 2 * int'(window_px[3]) + top_px);
      res.magnitude = edge_port_t'(((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy));
      res.row       = row_port_t'(row - 1);
      res.col       = col_port_t'(col - 1);
      res.last      = (row == FRAME_HEIGHT - 1) && (col == FRAME_WIDTH - 1);
      pending_edges.push_back(res);
    end

    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = pixel_t'(top_px);
    window_px[4] = pixel_t'(mid_px);
    window_px[5] = pixel_t'(pix);
    line_two_up[col] = pixel_t'(mid_px);
    line_one_up[col] = pixel_t'(pix);

    col++;
    if (col >= FRAME_WIDTH) begin
      col = 0;
      row++;
      if (row >= FRAME_HEIGHT) row = 0;
    end
    next_col = col;
    next_row = row;
  endfunction

  function automatic pix_port_t pattern_pixel(input pattern_e kind, input int r, input int c);
    case (kind)
      PAT_FLAT_LOW:   return '0;
      PAT_FLAT_HIGH:  return '1;
      PAT_VERT_EDGE:  return (c >= FRAME_WIDTH / 2) ? '1 : '0;
      PAT_HORIZ_EDGE: return (r >= 2) ? '1 : '0;
      // Anti-diagonal step: dark above-left, bright below-right
      PAT_DIAG_STEP:  return (r + c >= 160) ? '1 : '0;
      PAT_CHECKER:    return ((r ^ c) & 1) ? '1 : '0;
      PAT_RAMP:       return pix_port_t'(r * 7 + c * 3 + $urandom_range(0, 3));
      PAT_EXTREME:    return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:        return pix_port_t'($urandom);
    endcase
  endfunction

  // Present one pixel after a random gap and hold it until the transaction
  // completes; keep valid high when no gap is drawn.
  task automatic send_pixel(input pix_port_t pix, input logic fs);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    frame_start <= fs;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_edge(pix, fs);
  endtask

  // Stream count pixels in raster order, optionally opening a new frame
  task automatic send_run(input pattern_e kind, input int count, input bit with_start);
    for (int i = 0; i < count; i++)
      send_pixel(pattern_pixel(kind, i / FRAME_WIDTH, i % FRAME_WIDTH),
                 with_start && (i == 0));
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
  endtask

  // Open a bright frame, reach the first interior row, then darken it
  task automatic test_flat_images();
    send_run(PAT_FLAT_HIGH, 2 * FRAME_WIDTH + 10, 1'b1);
    send_run(PAT_FLAT_LOW, 20, 1'b0);
  endtask

  task automatic test_step_edges();
    send_run(PAT_VERT_EDGE, 20, 1'b0);
    send_run(PAT_HORIZ_EDGE, 20, 1'b0);
    send_run(PAT_DIAG_STEP, 20, 1'b0);
    send_run(PAT_CHECKER, 20, 1'b0);
  endtask

  // Restart the frame while results are flowing; the rows that follow
  // carry on from the restart
  task automatic test_restart_mid_frame();
    send_run(PAT_NOISE, 40, 1'b1);
  endtask

  // Pause the sender mid-row until the pipeline has fully drained
  task automatic test_pause_for_drain();
    send_run(PAT_NOISE, 30, 1'b0);
    wait_for_results();
    send_run(PAT_RAMP, 20, 1'b0);
  endtask

  // Two rows at full rate on both sides, without a frame start, so the
  // counters must wrap at the row end on their own and reach the interior.
  task automatic test_full_frame_wrap();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_run(PAT_EXTREME, 2 * FRAME_WIDTH, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Short runs continuing the open frame, with pattern and idling switched
  // per run.
  task automatic test_random_stream();
    int sent;
    int len;
    pattern_e kind;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      kind = pattern_e'($urandom_range(PAT_RAMP, PAT_NOISE));
      len = $urandom_range(1, 24);
      send_run(kind, len, 1'b0);
      sent += len;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < FRAME_WIDTH; i++) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_px[i] = '0;
    next_col = 0;
    next_row = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_flat_images();
    test_step_edges();
    test_pause_for_drain();
    test_restart_mid_frame();
    test_full_frame_wrap();
    test_random_stream();

    wait_for_results();
    // Allow for any stray result still in flight in the three-stage pipe
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_edges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver stalls: hold ready low for the number of cycles drawn after
  // each result transaction.
  always @(negedge clk) begin
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      ready_hold = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (pending_edges.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d unexpected: mag %0d row %0d col %0d last %0d",
                   results_seen, edge_magnitude, center_row, center_col, frame_last);
      end else begin
        want = pending_edges.pop_front();
        if (edge_magnitude !== want.magnitude || center_row !== want.row ||
            center_col !== want.col || frame_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: expected mag %0d row %0d col %0d last %0d, got mag %0d row %0d col %0d last %0d",
                     results_seen, want.magnitude, want.row, want.col, want.last,
                     edge_magnitude, center_row, center_col, frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

/* sobel_edge_magnitude_stream_unit.f */
rtl/sobel_pkg.sv
rtl/sobel_ram.sv
rtl/sobel_cell.sv
rtl/sobel_edge_magnitude_stream_unit.sv
rtl/sobel_checker.sv
verif/sobel_edge_magnitude_stream_unit_test.sv
